[design/dpb_pkg.sv]
package dpb_pkg;

  localparam int ZW = 16;
  localparam int PW = 12;
  localparam int DW = 17;
  localparam int NW = 41;
  localparam int FW = 16;
  localparam int QW = 41;

  // Divider shape: quotient bits per stage, stage count, and the latency of
  // one axis pipe (difference, multiply, division stages, saturation).
  localparam int BPS = 2;
  localparam int NDS = (QW + BPS - 1) / BPS;
  localparam int LAT = 2 + NDS + 1;

  typedef enum logic [1:0] {
    REG_FOCAL_X  = 2'd0,
    REG_FOCAL_Y  = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_index_t;

  localparam logic [15:0] FOCAL_X_RESET  = 16'd8192;
  localparam logic [15:0] FOCAL_Y_RESET  = 16'd8192;
  localparam logic [15:0] CENTER_X_RESET = 16'd5120;
  localparam logic [15:0] CENTER_Y_RESET = 16'd3840;

  typedef struct packed {
    logic       valid;
    logic       live;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [15:0] depth;
  } side_t;

endpackage

[design/dpb_axis.sv]
// Pipelined back-projection of one axis. Restoring division, two quotient
// bits per stage, fully pipelined so a new item may enter each cycle.
module dpb_axis
  import dpb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ZW-1:0]     depth,
  input  logic [PW-1:0]     pix,
  input  logic [15:0]       center,
  input  logic [15:0]       focal,
  output logic signed [31:0] pos
);

  // Stage 1: signed difference.
  logic          s1_v;
  logic          s1_neg;
  logic [DW-2:0] s1_diff;
  logic [ZW-1:0] s1_z;
  logic [FW-1:0] s1_den;

  logic [DW-1:0] pos16;
  logic [DW-1:0] cext;
  logic [DW-1:0] dsub;
  assign pos16 = {1'b0, pix, 4'b0};
  assign cext  = {1'b0, center};
  assign dsub  = pos16 - cext;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
    end
    s1_neg  <= cext > pos16;
    s1_diff <= (cext > pos16) ? (DW-1)'(cext - pos16) : dsub[DW-2:0];
    s1_z    <= depth;
    s1_den  <= (focal == '0) ? FW'(1) : focal;
  end

  // Stage 2: product z*diff, scaled by 256.
  logic          s2_v;
  logic          s2_neg;
  logic [NW-1:0] s2_num;
  logic [FW-1:0] s2_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_neg <= s1_neg;
    s2_num <= (NW'(s1_z) * NW'(s1_diff)) << 8;
    s2_den <= s1_den;
  end

  // Division stages. The stages walk one bit more than the numerator holds,
  // so the last step divides twice the numerator and the quotient is halved
  // at the end.
  logic          dv   [NDS+1];
  logic          dneg [NDS+1];
  logic [NW-1:0] dnum [NDS+1];
  logic [FW:0]   drem [NDS+1];
  logic [FW-1:0] dden [NDS+1];

  always_comb begin
    dv[0]   = s2_v;
    dneg[0] = s2_neg;
    dnum[0] = s2_num;
    drem[0] = '0;
    dden[0] = s2_den;
  end

  for (genvar g = 0; g < NDS; g++) begin : g_div
    logic [NW-1:0] n_nx;
    logic [FW:0]   r_nx;
    always_comb begin
      logic [FW+1:0] t;
      n_nx = dnum[g];
      r_nx = drem[g];
      for (int b = 0; b < BPS; b++) begin
        t = {r_nx, n_nx[NW-1]};
        n_nx = {n_nx[NW-2:0], 1'b0};
        if (t >= {2'b0, dden[g]}) begin
          t = t - {2'b0, dden[g]};
          n_nx[0] = 1'b1;
        end
        r_nx = t[FW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else begin
        dv[g+1] <= dv[g];
      end
      dneg[g+1] <= dneg[g];
      dnum[g+1] <= n_nx;
      drem[g+1] <= r_nx;
      dden[g+1] <= dden[g];
    end
  end

  // Final saturation and sign, registered.
  logic [QW-1:0] q;
  assign q = dnum[NDS] >> ((NDS * BPS) - QW);
  always_ff @(posedge clk) begin
    if (dneg[NDS]) begin
      pos <= (q > QW'(33'h080000000)) ? 32'sh80000000 : 32'(-q);
    end else begin
      pos <= (q > QW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : q[31:0];
    end
  end

  ap_rem: assert property (@(posedge clk) disable iff (rst)
    dv[NDS] |-> (drem[NDS] < {1'b0, dden[NDS]}))
    else $error("remainder not below divisor");
  ap_den: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> (s1_den != '0))
    else $error("zero divisor");
  ap_num: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (s2_num[NW-1] == 1'b0))
    else $error("numerator top bit set");

endmodule

[design/depth_pixel_backprojection_core.sv]
// Depth pixel back-projection through a pinhole camera model.
// The result strobe follows start through one difference stage, one
// multiply stage, 21 two-bit division stages and one saturation stage.
// Throughput: one item per cycle; busy is always low and start may be held.
// Reset (rst, synchronous) clears the pipeline valid bits and restores the
// default intrinsics. The receiver cannot stall; results are not held.
module depth_pixel_backprojection_core
  import dpb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [11:0]       column,
  input  logic [11:0]       row,
  input  logic [15:0]       depth_mm,
  input  logic [7:0]        red_in,
  input  logic [7:0]        green_in,
  input  logic [7:0]        blue_in,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              done,
  output logic              point_valid,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  output logic [15:0]       z_pos,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out
);

  // The pipeline never stalls, so the block is never busy.
  assign busy = 1'b0;

  logic [15:0] focal_x, focal_y, center_x, center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= FOCAL_X_RESET;
      focal_y  <= FOCAL_Y_RESET;
      center_x <= CENTER_X_RESET;
      center_y <= CENTER_Y_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // The colour, depth and valid bit travel alongside the two divider pipes.
  side_t side [LAT+1];
  always_comb begin
    side[0].valid = accept;
    side[0].live  = depth_mm != '0;
    side[0].red   = red_in;
    side[0].green = green_in;
    side[0].blue  = blue_in;
    side[0].depth = depth_mm;
  end

  for (genvar g = 0; g < LAT; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[g+1].valid <= 1'b0;
      end else begin
        side[g+1].valid <= side[g].valid;
      end
      side[g+1].live  <= side[g].live;
      side[g+1].red   <= side[g].red;
      side[g+1].green <= side[g].green;
      side[g+1].blue  <= side[g].blue;
      side[g+1].depth <= side[g].depth;
    end
  end

  logic signed [31:0] x_raw, y_raw;

  dpb_axis u_x (
    .clk(clk), .rst(rst), .in_valid(accept), .depth(depth_mm), .pix(column),
    .center(center_x), .focal(focal_x), .pos(x_raw)
  );

  dpb_axis u_y (
    .clk(clk), .rst(rst), .in_valid(accept), .depth(depth_mm), .pix(row),
    .center(center_y), .focal(focal_y), .pos(y_raw)
  );

  // An item with no depth reading comes out as an all-zero invalid point.
  side_t last;
  assign last = side[LAT];
  assign done        = last.valid;
  assign point_valid = last.live;
  assign x_pos       = last.live ? x_raw : '0;
  assign y_pos       = last.live ? y_raw : '0;
  assign z_pos       = last.depth;
  assign red_out     = last.live ? last.red : '0;
  assign green_out   = last.live ? last.green : '0;
  assign blue_out    = last.live ? last.blue : '0;

  ap_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching item");
  ap_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !point_valid) |-> (x_pos == 0 && y_pos == 0 && z_pos == 0))
    else $error("invalid point not zero");
  ap_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
